// ===== rtl/core/olde_pkg.sv =====
// Shared types and codes for the ordered list deque engine.
package olde_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_DELETE     = 3'd4;
   localparam logic [2:0] OP_PEEK_FRONT = 3'd5;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]                op;
      logic signed [VALUE_W-1:0] value;
      logic [COUNT_W-1:0]        max_remove;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] out_value;
      logic [1:0]                status;
      logic [COUNT_W-1:0]        removed_count;
      logic [COUNT_W-1:0]        occupancy;
   } rsp_type;

endpackage

// ===== rtl/core/olde_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module olde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ordered_list_deque_engine.sv =====
// Bounded double-ended queue of signed 32-bit values with delete by value.
//
// Input channel req_*: one transaction carries op, value and max_remove.
// Result channel rsp_*: exactly one transaction per request, in order, with
// out_value, status, removed_count and occupancy after the operation.
// Entries live in a circular RAM (one write and one read port, registered
// read); a small sequencer and one shared slot-address adder do all work.
// Sequencer steps per request: push and unused op codes run exec then result;
// pop and peek add a wait for the registered RAM read before the result;
// delete adds one read and one compare/write step per entry, then an end check.
// First result is valid the cycle after the last sequencer step.
// req_ready is high only while the sequencer is idle. The result sits in an
// output register, so a new request is taken while a result waits; a stalled
// receiver holds the sequencer at its final step until the register frees.
// Reset empties the store (front slot 0, no entries) and drops any pending
// result; stored values need no clearing since only held entries are read.
module ordered_list_deque_engine #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  olde_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output olde_pkg::rsp_type rsp_data
);
   import olde_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RDWAIT,
      S_DEL_RD,
      S_DEL_CHK,
      S_RESP
   } state_type;

   state_type                 state_ff, state_in;
   req_type                   req_ff, req_in;
   logic [AW-1:0]             first_ff, first_in;
   logic [CW-1:0]             fill_ff, fill_in;
   logic [CW-1:0]             rd_ff, rd_in;
   logic [CW-1:0]             wr_ff, wr_in;
   logic [COUNT_W-1:0]        removed_ff, removed_in;
   logic signed [VALUE_W-1:0] out_val_ff, out_val_in;
   logic [1:0]                status_ff, status_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0]      pos_sel;
   logic [SW-1:0]      slot_sum;
   logic [AW-1:0]      slot;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [VALUE_W-1:0] ram_wdata;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   logic [VALUE_W-1:0] ram_rdata;
   logic               is_full;
   logic               is_empty;

   assign is_full  = (fill_ff == DEPTH_C);
   assign is_empty = (fill_ff == '0);

   // Shared slot adder: logical position to circular store slot.
   always_comb begin
      pos_sel = fill_ff;
      case (state_ff)
         S_EXEC: begin
            case (req_ff.op)
               OP_PUSH_FRONT: pos_sel = CW'(DEPTH - 1);
               OP_PUSH_BACK:  pos_sel = fill_ff;
               OP_POP_FRONT:  pos_sel = CW'(1);
               OP_POP_BACK:   pos_sel = fill_ff - 1'b1;
               default:       pos_sel = fill_ff;
            endcase
         end
         S_DEL_RD:  pos_sel = rd_ff;
         S_DEL_CHK: pos_sel = wr_ff;
         default:   pos_sel = fill_ff;
      endcase
   end

   assign slot_sum = SW'(first_ff) + SW'(pos_sel);
   assign slot     = (slot_sum >= DEPTH_S) ? AW'(slot_sum - DEPTH_S) : AW'(slot_sum);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      first_in     = first_ff;
      fill_in      = fill_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      removed_in   = removed_ff;
      out_val_in   = out_val_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;
      ram_waddr    = slot;
      ram_wdata    = VALUE_W'(req_ff.value);
      ram_re       = 1'b0;
      ram_raddr    = slot;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            out_val_in = '0;
            status_in  = STATUS_OK;
            removed_in = '0;
            state_in   = S_RESP;
            case (req_ff.op)
               OP_PUSH_FRONT: begin
                  if (is_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     ram_we   = 1'b1;
                     first_in = slot;
                     fill_in  = fill_ff + 1'b1;
                  end
               end
               OP_PUSH_BACK: begin
                  if (is_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     ram_we  = 1'b1;
                     fill_in = fill_ff + 1'b1;
                  end
               end
               OP_POP_FRONT: begin
                  if (is_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = first_ff;
                     first_in  = slot;
                     fill_in   = fill_ff - 1'b1;
                     state_in  = S_RDWAIT;
                  end
               end
               OP_POP_BACK: begin
                  if (is_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     ram_re   = 1'b1;
                     fill_in  = fill_ff - 1'b1;
                     state_in = S_RDWAIT;
                  end
               end
               OP_PEEK_FRONT: begin
                  if (is_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = first_ff;
                     state_in  = S_RDWAIT;
                  end
               end
               OP_DELETE: begin
                  rd_in    = '0;
                  wr_in    = '0;
                  state_in = S_DEL_RD;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_RDWAIT: begin
            out_val_in = signed'(ram_rdata);
            state_in   = S_RESP;
         end
         S_DEL_RD: begin
            if (rd_ff == fill_ff) begin
               fill_in  = wr_ff;
               state_in = S_RESP;
            end else begin
               ram_re   = 1'b1;
               rd_in    = rd_ff + 1'b1;
               state_in = S_DEL_CHK;
            end
         end
         S_DEL_CHK: begin
            // Matches are dropped until the limit; kept entries slide toward the front.
            if (ram_rdata == VALUE_W'(req_ff.value) && removed_ff < req_ff.max_remove) begin
               removed_in = removed_ff + 1'b1;
            end else begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata;
               wr_in     = wr_ff + 1'b1;
            end
            state_in = S_DEL_RD;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.out_value     = out_val_ff;
               rsp_in.status        = status_ff;
               rsp_in.removed_count = removed_ff;
               rsp_in.occupancy     = COUNT_W'(fill_ff);
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      rd_ff      <= rd_in;
      wr_ff      <= wr_in;
      removed_ff <= removed_in;
      out_val_ff <= out_val_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
   end

   olde_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_C)
      else $error("fill count above depth");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEL_RD || state_ff == S_DEL_CHK) |-> (wr_ff <= rd_ff && rd_ff <= fill_ff))
      else $error("delete write pointer passed read pointer");

   a_remove_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEL_CHK) |-> (removed_ff <= req_ff.max_remove))
      else $error("delete removed more than requested");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one in progress");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("result posted outside final sequencer step");

endmodule
